@@ design/mvm_pkg.sv @@
// Shared types and constants for the streamed matrix-vector multiply.
// No dependencies; every other file in the design refers to it by scoped names.
`default_nettype none

package mvm_pkg;

    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 3;
    localparam int ROW_OUT_W   = 4;
    // Position arithmetic width: holds COLS up to 64 plus an index without wrap.
    localparam int POS_W       = 7;
    localparam int QUEUE_DEPTH = 3;
    localparam int QPTR_W      = 2;
    localparam int LEVEL_W     = 2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

    typedef logic [DATA_W-1:0] data_t;

    // Control that rides with one product through the multiply stage.
    typedef struct packed {
        logic                 valid;
        logic                 last_col;
        logic                 final_row;
        logic [ROW_OUT_W-1:0] row;
    } mac_ctrl_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        data_t                dot_product;
        logic                 final_row;
    } result_t;

endpackage

`default_nettype wire

@@ design/matrix_vector_multiply_core.sv @@
// Channel   Ports                                   Moves
// input     s_valid s_ready s_kind s_index s_value   vector load or matrix element
// result    m_valid m_ready m_row m_dot_product      one finished row
//           m_final_row
// One item transfers per cycle while s_ready is high; a finished row is queued.
// The 32x32 multiply is registered, then added into the row accumulator.
// Vector elements sit in a ring of COLS cells that rotates once per matrix element.
// A three-entry result queue lets input run on while results wait; s_ready drops only
// when the queue and the multiply stage together could not absorb another row.
// Synchronous active-low reset clears counters, accumulator and queue, not vector cells.
`default_nettype none

module matrix_vector_multiply_core #(
    parameter int COLS = 8,
    parameter int ROWS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_kind,
    input  wire logic [mvm_pkg::INDEX_W-1:0]       s_index,
    input  wire logic signed [mvm_pkg::DATA_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [mvm_pkg::ROW_OUT_W-1:0]          m_row,
    output logic signed [mvm_pkg::DATA_W-1:0]      m_dot_product,
    output logic                                   m_final_row
);

    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [mvm_pkg::POS_W-1:0] COLS_POS = mvm_pkg::POS_W'(COLS);

    logic [COL_W-1:0]                   col_reg;
    logic [COL_W-1:0]                   col_next;
    logic [ROW_W-1:0]                   row_cnt_reg;
    logic [ROW_W-1:0]                   row_cnt_next;
    logic [ROW_W+mvm_pkg::ROW_OUT_W-1:0] row_wide;
    logic                               accept;
    logic                               mat_accept;
    logic                               load_accept;
    logic                               is_last_col;
    logic                               is_final_row;
    logic [mvm_pkg::POS_W-1:0]          idx_pos;
    logic [mvm_pkg::POS_W-1:0]          col_pos;
    logic [mvm_pkg::POS_W-1:0]          phys_pos;
    logic                               idx_in_range;
    mvm_pkg::data_t                     elem [COLS];
    mvm_pkg::mac_ctrl_t                 mac_ctrl;
    logic                               last_pending;
    logic                               push_valid;
    mvm_pkg::result_t                   push_data;
    mvm_pkg::result_t                   out_data;
    logic [mvm_pkg::LEVEL_W-1:0]        level;
    logic [mvm_pkg::LEVEL_W:0]          committed;

    // Reserve a queue slot for a row end still in the multiply stage.
    assign committed = {1'b0, level} + {{mvm_pkg::LEVEL_W{1'b0}}, last_pending};
    assign s_ready   = (committed <= (mvm_pkg::LEVEL_W + 1)'(mvm_pkg::QUEUE_DEPTH - 1));

    assign accept      = s_valid && s_ready;
    assign mat_accept  = accept && (s_kind == mvm_pkg::KIND_MATRIX);
    assign load_accept = accept && (s_kind == mvm_pkg::KIND_LOAD);

    assign is_last_col  = (col_reg == LAST_COL);
    assign is_final_row = (row_cnt_reg == LAST_ROW);

    always_comb begin
        col_next     = col_reg;
        row_cnt_next = row_cnt_reg;
        if (mat_accept) begin
            if (is_last_col) begin
                col_next     = '0;
                row_cnt_next = is_final_row ? '0 : row_cnt_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_cnt_reg <= '0;
        end else begin
            col_reg     <= col_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Cell p holds logical element (p + col) mod COLS; map a load index back to its cell.
    assign idx_pos      = mvm_pkg::POS_W'(s_index);
    assign col_pos      = mvm_pkg::POS_W'(col_reg);
    assign idx_in_range = (idx_pos < COLS_POS);
    assign phys_pos     = (idx_pos >= col_pos) ? (idx_pos - col_pos)
                                               : (idx_pos + COLS_POS - col_pos);

    for (genvar i = 0; i < COLS; i++) begin : g_cell
        mvm_cell u_cell (
            .aclk       (aclk),
            .shift_en   (mat_accept),
            .load_en    (load_accept && idx_in_range
                         && (phys_pos == mvm_pkg::POS_W'(i))),
            .load_data  (s_value),
            .shift_data (elem[(i + 1) % COLS]),
            .elem       (elem[i])
        );
    end

    assign row_wide = {{mvm_pkg::ROW_OUT_W{1'b0}}, row_cnt_reg};

    assign mac_ctrl.valid     = mat_accept;
    assign mac_ctrl.last_col  = is_last_col;
    assign mac_ctrl.final_row = is_final_row;
    assign mac_ctrl.row       = row_wide[mvm_pkg::ROW_OUT_W-1:0];

    mvm_mac u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_ctrl      (mac_ctrl),
        .in_value     (s_value),
        .in_vec       (elem[0]),
        .last_pending (last_pending),
        .push_valid   (push_valid),
        .push_data    (push_data)
    );

    mvm_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop_ready  (m_ready),
        .pop_valid  (m_valid),
        .pop_data   (out_data),
        .level      (level)
    );

    assign m_row         = out_data.row;
    assign m_dot_product = out_data.dot_product;
    assign m_final_row   = out_data.final_row;

endmodule

`default_nettype wire

@@ design/mvm_cell.sv @@
// One vector cell of the rotating element ring.
// Depends on mvm_pkg for the element type.
`default_nettype none

module mvm_cell (
    input  wire logic          aclk,
    input  wire logic          shift_en,
    input  wire logic          load_en,
    input  wire mvm_pkg::data_t load_data,
    input  wire mvm_pkg::data_t shift_data,
    output mvm_pkg::data_t      elem
);

    mvm_pkg::data_t elem_reg;

    // Contents are undefined until loaded, so no reset.
    always_ff @(posedge aclk) begin
        if (load_en) begin
            elem_reg <= load_data;
        end else if (shift_en) begin
            elem_reg <= shift_data;
        end
    end

    assign elem = elem_reg;

endmodule

`default_nettype wire

@@ design/mvm_mac.sv @@
// Multiply stage and row accumulator; emits one result per finished row.
// Depends on mvm_pkg for the control and result structs.
`default_nettype none

module mvm_mac (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mvm_pkg::mac_ctrl_t in_ctrl,
    input  wire mvm_pkg::data_t     in_value,
    input  wire mvm_pkg::data_t     in_vec,
    output logic                    last_pending,
    output logic                    push_valid,
    output mvm_pkg::result_t        push_data
);

    mvm_pkg::mac_ctrl_t ctrl_reg;
    mvm_pkg::data_t     prod_reg;
    mvm_pkg::data_t     acc_reg;
    mvm_pkg::data_t     acc_next;
    mvm_pkg::data_t     sum;

    // Low half of the product only; wraps the same for signed and unsigned.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else begin
            ctrl_reg.valid <= in_ctrl.valid;
        end
        ctrl_reg.last_col  <= in_ctrl.last_col;
        ctrl_reg.final_row <= in_ctrl.final_row;
        ctrl_reg.row       <= in_ctrl.row;
        prod_reg           <= in_value * in_vec;
    end

    assign sum = acc_reg + prod_reg;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl_reg.valid) begin
            acc_next = ctrl_reg.last_col ? '0 : sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign last_pending          = ctrl_reg.valid && ctrl_reg.last_col;
    assign push_valid            = last_pending;
    assign push_data.row         = ctrl_reg.row;
    assign push_data.dot_product = sum;
    assign push_data.final_row   = ctrl_reg.final_row;

endmodule

`default_nettype wire

@@ design/mvm_out_queue.sv @@
// Small result queue between the accumulator and the output channel.
// Depends on mvm_pkg for the result struct and the queue depth.
`default_nettype none

module mvm_out_queue (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push_valid,
    input  wire mvm_pkg::result_t              push_data,
    input  wire logic                          pop_ready,
    output logic                               pop_valid,
    output mvm_pkg::result_t                   pop_data,
    output logic [mvm_pkg::LEVEL_W-1:0]        level
);

    mvm_pkg::result_t                   entry_reg [mvm_pkg::QUEUE_DEPTH];
    logic [mvm_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [mvm_pkg::QPTR_W-1:0]         wr_ptr_next;
    logic [mvm_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [mvm_pkg::QPTR_W-1:0]         rd_ptr_next;
    logic [mvm_pkg::LEVEL_W-1:0]        count_reg;
    logic [mvm_pkg::LEVEL_W-1:0]        count_next;
    logic                               pop;

    localparam logic [mvm_pkg::QPTR_W-1:0] LAST_PTR =
        mvm_pkg::QPTR_W'(mvm_pkg::QUEUE_DEPTH - 1);

    assign pop = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign level     = count_reg;

endmodule

`default_nettype wire

@@ design/mvm_checker.sv @@
// Port-level checker for the matrix-vector multiply core, bound to the top level.
// Depends on mvm_pkg for field widths.
`default_nettype none

module mvm_checker #(
    parameter int ROWS = 16
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [mvm_pkg::ROW_OUT_W-1:0]     m_row,
    input wire logic signed [mvm_pkg::DATA_W-1:0] m_dot_product,
    input wire logic                              m_final_row
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [ROW_W-1:0]                    exp_row_reg;
    logic [ROW_W+mvm_pkg::ROW_OUT_W-1:0] exp_wide;
    logic                                out_xfer;

    assign out_xfer = m_valid && m_ready;
    assign exp_wide = {{mvm_pkg::ROW_OUT_W{1'b0}}, exp_row_reg};

    // Track the row that the next result transfer must carry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_row_reg <= '0;
        end else if (out_xfer) begin
            exp_row_reg <= (exp_row_reg == LAST_ROW) ? '0 : exp_row_reg + 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dot_product) && $stable(m_row))
        else $error("stalled result changed");

    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_row == exp_wide[mvm_pkg::ROW_OUT_W-1:0])
        else $error("result row out of sequence");

    a_final_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_final_row == (exp_row_reg == LAST_ROW))
        else $error("final row flag mismatch");

endmodule

bind matrix_vector_multiply_core mvm_checker #(.ROWS(ROWS)) u_mvm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_row         (m_row),
    .m_dot_product (m_dot_product),
    .m_final_row   (m_final_row)
);

`default_nettype wire
